>>> rtl/core/uer_pkg.sv
// Shared constants and types for the ultrasonic echo ranger.
// No dependencies; uer_ctrl, uer_fifo and the top level import this package.
package uer_pkg;

    localparam int TRIG_W     = 10;
    localparam int TOUT_W     = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;

    localparam int FIFO_DEPTH_DEFAULT = 128;
    localparam int COUNT_BITS_DEFAULT = 24;

    localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RESET = TRIG_W'(20);
    localparam logic [TOUT_W-1:0] TIMEOUT_TICKS_RESET = TOUT_W'(50000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER_TICKS = 1'b0,
        REG_TIMEOUT_TICKS = 1'b1
    } cfg_reg_t;

    // Push request from the timing control to the result queue.
    typedef struct packed {
        logic push;
        logic is_timeout;
    } push_req_t;

endpackage

>>> rtl/core/uer_ctrl.sv
// Trigger pulse, echo measurement and timeout timing for the echo ranger.
// Holds the configuration registers; depends on uer_pkg.
module uer_ctrl #(
    parameter int COUNT_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                        accept,
    input  logic                        echo_level,
    input  logic                        start_request,
    output logic                        trigger_level,
    output uer_pkg::push_req_t          push_req,
    output logic [COUNT_BITS-1:0]       push_count
);
    import uer_pkg::*;

    logic [TRIG_W-1:0]     trigger_ticks_reg;
    logic [TOUT_W-1:0]     timeout_ticks_reg;
    logic                  echo_prev_reg, echo_prev_next;
    logic                  measuring_reg, measuring_next;
    logic [COUNT_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TRIG_W-1:0]     trig_left_reg, trig_left_next;
    logic                  armed_reg, armed_next;
    logic [TOUT_W-1:0]     tout_left_reg, tout_left_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_ticks_reg <= TRIGGER_TICKS_RESET;
            timeout_ticks_reg <= TIMEOUT_TICKS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_idx))
                REG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_wdata[TRIG_W-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata[TOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Steps follow the tick order: start, echo edge, timeout, trigger.
    always_comb begin
        echo_prev_next = echo_prev_reg;
        measuring_next = measuring_reg;
        elapsed_next   = elapsed_reg;
        trig_left_next = trig_left_reg;
        armed_next     = armed_reg;
        tout_left_next = tout_left_reg;
        push_req       = '0;
        push_count     = '0;
        trigger_level  = 1'b0;
        if (accept) begin
            if (start_request) begin
                trig_left_next = trigger_ticks_reg;
                armed_next     = 1'b0;
            end

            if (echo_level && !echo_prev_reg) begin
                measuring_next = 1'b1;
                elapsed_next   = COUNT_BITS'(1);
            end else if (echo_level && measuring_reg) begin
                if (elapsed_reg != '1) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end else if (!echo_level && echo_prev_reg && measuring_reg) begin
                measuring_next = 1'b0;
                armed_next     = 1'b0;
                push_req.push  = 1'b1;
                push_count     = elapsed_reg;
            end
            echo_prev_next = echo_level;

            // A zero timeout length expires like a length of one.
            if (armed_next) begin
                if (tout_left_reg <= TOUT_W'(1)) begin
                    tout_left_next      = '0;
                    armed_next          = 1'b0;
                    push_req.push       = 1'b1;
                    push_req.is_timeout = 1'b1;
                    push_count          = '0;
                end else begin
                    tout_left_next = tout_left_reg - 1'b1;
                end
            end

            trigger_level = (trig_left_next != '0);
            if (trig_left_next != '0) begin
                if (trig_left_next == TRIG_W'(1)) begin
                    armed_next     = 1'b1;
                    tout_left_next = timeout_ticks_reg;
                end
                trig_left_next = trig_left_next - 1'b1;
            end else if (start_request) begin
                armed_next     = 1'b1;
                tout_left_next = timeout_ticks_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_prev_reg <= 1'b0;
            measuring_reg <= 1'b0;
            elapsed_reg   <= '0;
            trig_left_reg <= '0;
            armed_reg     <= 1'b0;
            tout_left_reg <= '0;
        end else begin
            echo_prev_reg <= echo_prev_next;
            measuring_reg <= measuring_next;
            elapsed_reg   <= elapsed_next;
            trig_left_reg <= trig_left_next;
            armed_reg     <= armed_next;
            tout_left_reg <= tout_left_next;
        end
    end

endmodule

>>> rtl/core/uer_fifo.sv
// Ring queue of measurement results, one slot kept free, with pop logic.
// The store is a memory with a registered read port; depends on uer_pkg.
module uer_fifo #(
    parameter int FIFO_DEPTH = 128,
    parameter int COUNT_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  pop_request,
    input  uer_pkg::push_req_t    push_req,
    input  logic [COUNT_BITS-1:0] push_count,
    output logic                  read_valid,
    output logic                  read_is_timeout,
    output logic [COUNT_BITS-1:0] read_ticks,
    output logic                  fifo_empty
);
    import uer_pkg::*;

    localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int ENTRY_W = COUNT_BITS + 1;
    localparam logic [PTR_W:0] DEPTH_VAL = (PTR_W+1)'(FIFO_DEPTH);

    logic [ENTRY_W-1:0] store [FIFO_DEPTH];
    logic [ENTRY_W-1:0] mem_q_reg;
    logic [ENTRY_W-1:0] byp_data_reg;
    logic               byp_reg;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   wr_slot;
    logic               full, wr_en, was_empty, pop_ok;
    logic [ENTRY_W-1:0] entry_in, head, pop_entry;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign entry_in  = {push_req.is_timeout, push_count};
    assign wr_slot   = next_slot(wr_reg);
    assign full      = (wr_slot == rd_reg);
    assign wr_en     = accept && push_req.push && !full;
    assign wr_next   = wr_en ? wr_slot : wr_reg;
    assign was_empty = (rd_reg == wr_reg);
    assign pop_ok    = accept && pop_request && (rd_reg != wr_next);
    assign rd_next   = pop_ok ? next_slot(rd_reg) : rd_reg;

    // The head slot is read every cycle; a write to it in the same cycle is
    // forwarded through the bypass register.
    assign head      = byp_reg ? byp_data_reg : mem_q_reg;
    assign pop_entry = was_empty ? entry_in : head;

    always_comb begin
        read_valid      = pop_ok;
        read_is_timeout = 1'b0;
        read_ticks      = '0;
        if (pop_ok) begin
            read_is_timeout = pop_entry[COUNT_BITS];
            if (!pop_entry[COUNT_BITS]) begin
                read_ticks = pop_entry[COUNT_BITS-1:0];
            end
        end
    end
    assign fifo_empty = (rd_next == wr_next);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_reg] <= entry_in;
        end
        mem_q_reg    <= store[rd_next];
        byp_data_reg <= entry_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            byp_reg <= 1'b0;
        end else begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            byp_reg <= wr_en && (wr_reg == rd_next);
        end
    end

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, rd_reg} < DEPTH_VAL) && ({1'b0, wr_reg} < DEPTH_VAL))
        else $error("queue pointer outside the store");

    a_drop_keeps_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && push_req.push && full |=> wr_reg == $past(wr_reg))
        else $error("dropped entry moved the write pointer");

    a_pop_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        read_valid |-> !was_empty || wr_en)
        else $error("pop delivered from an empty queue");

endmodule

>>> rtl/core/uer_outbuf.sv
// Two-entry result buffer: output register plus skid register.
// Lets the core take a new beat while a finished one waits; no dependencies.
module uer_outbuf #(
    parameter int DATA_W = 29
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    logic              out_v_reg;
    logic              skid_v_reg;
    logic [DATA_W-1:0] out_d_reg;
    logic [DATA_W-1:0] skid_d_reg;
    logic              push, drain;

    assign in_ready  = !skid_v_reg;
    assign push      = in_valid && in_ready;
    assign drain     = out_v_reg && out_ready;
    assign out_valid = out_v_reg;
    assign out_data  = out_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (drain || !out_v_reg) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= push;
            end else begin
                out_v_reg <= push;
            end
        end else if (push) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain || !out_v_reg) begin
            if (skid_v_reg) begin
                out_d_reg <= skid_d_reg;
                if (push) begin
                    skid_d_reg <= in_data;
                end
            end else if (push) begin
                out_d_reg <= in_data;
            end
        end else if (push) begin
            skid_d_reg <= in_data;
        end
    end

endmodule

>>> rtl/core/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level: trigger, echo timer, result queue, output buffer.
// A result beat is registered in the output register, or first in the skid register while that one is held.
// Throughput: one input beat per cycle while s_ready is high; the two-entry output buffer sets the stall depth.
// Reset (synchronous, aresetn low) clears timing state and queue pointers, and
// loads trigger_ticks 20 and timeout_ticks 50000; the store itself is not cleared.
module ultrasonic_echo_ranger #(
    parameter int FIFO_DEPTH = uer_pkg::FIFO_DEPTH_DEFAULT,
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_echo_level,
    input  logic                           s_start_request,
    input  logic                           s_pop_request,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_trigger_level,
    output logic                           m_read_valid,
    output logic                           m_read_is_timeout,
    output logic [COUNT_BITS-1:0]          m_read_ticks,
    output logic                           m_fifo_empty,
    output logic                           m_data_pushed
);
    import uer_pkg::*;

    localparam int RES_W = COUNT_BITS + 5;

    logic                  accept;
    logic                  trigger_level;
    push_req_t             push_req;
    logic [COUNT_BITS-1:0] push_count;
    logic                  read_valid, read_is_timeout, fifo_empty;
    logic [COUNT_BITS-1:0] read_ticks;
    logic [RES_W-1:0]      res_data, res_out;

    assign accept = s_valid && s_ready;

    uer_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .accept        (accept),
        .echo_level    (s_echo_level),
        .start_request (s_start_request),
        .trigger_level (trigger_level),
        .push_req      (push_req),
        .push_count    (push_count)
    );

    uer_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_fifo (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .pop_request     (s_pop_request),
        .push_req        (push_req),
        .push_count      (push_count),
        .read_valid      (read_valid),
        .read_is_timeout (read_is_timeout),
        .read_ticks      (read_ticks),
        .fifo_empty      (fifo_empty)
    );

    assign res_data = {trigger_level, read_valid, read_is_timeout, read_ticks,
                       fifo_empty, push_req.push};

    uer_outbuf #(
        .DATA_W (RES_W)
    ) u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (res_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out)
    );

    assign m_trigger_level   = res_out[RES_W-1];
    assign m_read_valid      = res_out[RES_W-2];
    assign m_read_is_timeout = res_out[RES_W-3];
    assign m_read_ticks      = res_out[COUNT_BITS+1:2];
    assign m_fifo_empty      = res_out[1];
    assign m_data_pushed     = res_out[0];

endmodule
